FILE: sv/keyed_rate_table_max_vote_macros.svh
// assertion helpers used by the rate table top module
`ifndef KEYED_RATE_TABLE_MAX_VOTE_MACROS_SVH
`define KEYED_RATE_TABLE_MAX_VOTE_MACROS_SVH

// same-cycle implication, checked outside reset
`define KRV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define KRV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/krv_pkg.sv
`default_nettype none

package krv_pkg;

  localparam int unsigned KEY_W = 32;

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_UPDATE = 3'd2,
    CMD_ANIM   = 3'd3,
    CMD_SYNC   = 3'd4,
    CMD_FLAG   = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_APPLIED = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_APPLY
  } state_t;

  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

endpackage

`default_nettype wire

FILE: sv/keyed_rate_table_max_vote.sv
// keyed rate table with maximum vote
// input channel: in_valid / in_stall carries one command item (cmd, node_id,
// rate_value, flag_value); it is taken when in_valid is high and in_stall low
// result channel: out_valid / out_stall returns one result per item: the
// expected rate, the changed flag, the display sync rate and a status
// each item walks every table entry once through a single key compare and
// max unit, one entry per cycle through the table's registered read port
// after accept the item passes S_SCAN over every entry, then S_WAIT, then
// S_APPLY, where it commits its result to the output register; the next item
// is taken only once the block is back in S_IDLE, not while one is in flight
// in_stall is high from accept until the result is written to the output
// register; a stalled result holds, and the block may accept and scan the
// next item while it waits, holding that item's commit until the slot frees
// reset (synchronous, rst_n low) empties the table and clears the animation
// rate, display sync rate, changed flag and any pending result
`default_nettype none

`include "keyed_rate_table_max_vote_macros.svh"

module keyed_rate_table_max_vote import krv_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 32,
  parameter int unsigned RATE_BITS     = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [2:0]           in_cmd,
  input  wire logic signed [31:0]   in_node_id,
  input  wire logic [RATE_BITS-1:0] in_rate_value,
  input  wire logic                 in_flag_value,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [RATE_BITS-1:0]      out_expected_rate,
  output logic                      out_rate_changed,
  output logic [RATE_BITS-1:0]      out_display_sync_rate,
  output logic [1:0]                out_status
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             step_r;
  logic [IDX_W-1:0] idx_r;
  logic             accept;
  logic             commit;

  logic [2:0]           cmd_r;
  logic [KEY_W-1:0]     key_r;
  logic [RATE_BITS-1:0] rate_r;
  logic                 flag_r;

  logic [RATE_BITS-1:0] anim_r, anim_nxt;
  logic [RATE_BITS-1:0] sync_r, sync_nxt;
  logic                 chg_r, chg_nxt;

  logic                 out_valid_r;
  logic [RATE_BITS-1:0] out_rate_r;
  logic                 out_chg_r;
  logic [RATE_BITS-1:0] out_sync_r;
  status_t              out_status_r;

  scan_ctl_t            scan_ctl;
  logic                 ent_valid;
  logic [KEY_W-1:0]     ent_key;
  logic [RATE_BITS-1:0] ent_rate;
  logic                 hit;
  logic [IDX_W-1:0]     hit_slot;
  logic [RATE_BITS-1:0] hit_rate;
  logic                 free;
  logic [IDX_W-1:0]     free_slot;
  logic [RATE_BITS-1:0] max_other;

  logic                 wr_hit;
  logic                 wr_free;
  logic                 clr_hit;
  logic [RATE_BITS-1:0] incl_rate;
  logic [RATE_BITS-1:0] max_a;
  logic [RATE_BITS-1:0] max_b;
  logic [RATE_BITS-1:0] max_fin;
  status_t              status;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign commit   = (state_r == S_APPLY) && !(out_valid_r && out_stall);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(TABLE_ENTRIES - 1)) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      step_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      step_r  <= (state_r == S_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= cnt_r[IDX_W-1:0];
    if (accept) begin
      cmd_r  <= in_cmd;
      key_r  <= in_node_id;
      rate_r <= in_rate_value;
      flag_r <= in_flag_value;
    end
  end

  assign scan_ctl.clear = accept;
  assign scan_ctl.step  = step_r;

  krv_table #(
    .ENTRIES (TABLE_ENTRIES),
    .RATE_W  (RATE_BITS),
    .IDX_W   (IDX_W)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_addr   (cnt_r[IDX_W-1:0]),
    .rd_valid  (ent_valid),
    .rd_key    (ent_key),
    .rd_rate   (ent_rate),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_key    (key_r),
    .wr_rate   (rate_r),
    .set_valid (commit && wr_free),
    .clr_valid (commit && clr_hit)
  );

  krv_scan #(
    .RATE_W (RATE_BITS),
    .IDX_W  (IDX_W)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (scan_ctl),
    .idx       (idx_r),
    .key       (key_r),
    .ent_valid (ent_valid),
    .ent_key   (ent_key),
    .ent_rate  (ent_rate),
    .hit       (hit),
    .hit_slot  (hit_slot),
    .hit_rate  (hit_rate),
    .free      (free),
    .free_slot (free_slot),
    .max_other (max_other)
  );

  // command decision once the scan is complete; the matched entry was left out
  // of max_other, so its surviving rate comes back in through incl_rate
  always_comb begin
    wr_hit    = 1'b0;
    wr_free   = 1'b0;
    clr_hit   = 1'b0;
    incl_rate = hit ? hit_rate : '0;
    anim_nxt  = anim_r;
    sync_nxt  = sync_r;
    chg_nxt   = chg_r;
    status    = ST_IGNORED;
    case (cmd_t'(cmd_r))
      CMD_ADD: begin
        if (!hit) begin
          if (free) begin
            wr_free   = 1'b1;
            incl_rate = rate_r;
            chg_nxt   = 1'b1;
            status    = ST_APPLIED;
          end else begin
            status = ST_FULL;
          end
        end
      end
      CMD_REMOVE: begin
        if (hit) begin
          clr_hit   = 1'b1;
          incl_rate = '0;
          chg_nxt   = 1'b1;
          status    = ST_APPLIED;
        end
      end
      CMD_UPDATE: begin
        if (hit && hit_rate != rate_r) begin
          wr_hit    = 1'b1;
          incl_rate = rate_r;
          chg_nxt   = 1'b1;
          status    = ST_APPLIED;
        end
      end
      CMD_ANIM: begin
        if (anim_r != rate_r) begin
          anim_nxt = rate_r;
          chg_nxt  = 1'b1;
          status   = ST_APPLIED;
        end
      end
      CMD_SYNC: begin
        if (sync_r != rate_r) begin
          sync_nxt = rate_r;
          chg_nxt  = 1'b1;
          status   = ST_APPLIED;
        end
      end
      CMD_FLAG: begin
        chg_nxt = flag_r;
        status  = ST_APPLIED;
      end
      default: begin
        status = ST_IGNORED;
      end
    endcase
  end

  assign wr_en   = commit && (wr_hit || wr_free);
  assign wr_addr = wr_free ? free_slot : hit_slot;

  assign max_a   = (incl_rate > max_other) ? incl_rate : max_other;
  assign max_b   = (sync_nxt > anim_nxt) ? sync_nxt : anim_nxt;
  assign max_fin = (max_a > max_b) ? max_a : max_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anim_r      <= '0;
      sync_r      <= '0;
      chg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (commit) begin
        anim_r      <= anim_nxt;
        sync_r      <= sync_nxt;
        chg_r       <= chg_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_rate_r   <= max_fin;
      out_chg_r    <= chg_nxt;
      out_sync_r   <= sync_nxt;
      out_status_r <= status;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_expected_rate     = out_rate_r;
  assign out_rate_changed      = out_chg_r;
  assign out_display_sync_rate = out_sync_r;
  assign out_status            = out_status_r;

  `KRV_ASSERT_NEXT(a_accept_starts_scan, accept, (state_r == S_SCAN) && (cnt_r == '0), "scan did not start at entry zero")
  `KRV_ASSERT_NEXT(a_commit_shows_result, commit, out_valid_r && (state_r == S_IDLE), "committed item did not reach the output")
  `KRV_ASSERT_NOW(a_vote_covers_sync, out_valid_r, out_expected_rate >= out_display_sync_rate, "expected rate below display sync rate")
  `KRV_ASSERT_NOW(a_full_only_on_add, commit && (status == ST_FULL), cmd_r == CMD_ADD, "table full reported for a non-add command")

endmodule

`default_nettype wire

FILE: sv/krv_table.sv
`default_nettype none

module krv_table import krv_pkg::*; #(
  parameter int unsigned ENTRIES   = 32,
  parameter int unsigned RATE_W    = 10,
  parameter int unsigned IDX_W     = 5
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [IDX_W-1:0]  rd_addr,
  output logic                   rd_valid,
  output logic [KEY_W-1:0]       rd_key,
  output logic [RATE_W-1:0]      rd_rate,
  input  wire logic              wr_en,
  input  wire logic [IDX_W-1:0]  wr_addr,
  input  wire logic [KEY_W-1:0]  wr_key,
  input  wire logic [RATE_W-1:0] wr_rate,
  input  wire logic              set_valid,
  input  wire logic              clr_valid
);

  logic [KEY_W-1:0]  key_mem  [ENTRIES];
  logic [RATE_W-1:0] rate_mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic               rd_valid_r;
  logic [KEY_W-1:0]   rd_key_r;
  logic [RATE_W-1:0]  rd_rate_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]  <= wr_key;
      rate_mem[wr_addr] <= wr_rate;
    end
    rd_key_r  <= key_mem[rd_addr];
    rd_rate_r <= rate_mem[rd_addr];
  end

  // valid bits live in flops so reset empties the table at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (set_valid) begin
        valid_r[wr_addr] <= 1'b1;
      end else if (clr_valid) begin
        valid_r[wr_addr] <= 1'b0;
      end
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  assign rd_valid = rd_valid_r;
  assign rd_key   = rd_key_r;
  assign rd_rate  = rd_rate_r;

endmodule

`default_nettype wire

FILE: sv/krv_scan.sv
`default_nettype none

module krv_scan import krv_pkg::*; #(
  parameter int unsigned RATE_W = 10,
  parameter int unsigned IDX_W  = 5
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire scan_ctl_t         ctl,
  input  wire logic [IDX_W-1:0]  idx,
  input  wire logic [KEY_W-1:0]  key,
  input  wire logic              ent_valid,
  input  wire logic [KEY_W-1:0]  ent_key,
  input  wire logic [RATE_W-1:0] ent_rate,
  output logic                   hit,
  output logic [IDX_W-1:0]       hit_slot,
  output logic [RATE_W-1:0]      hit_rate,
  output logic                   free,
  output logic [IDX_W-1:0]       free_slot,
  output logic [RATE_W-1:0]      max_other
);

  logic              hit_r, hit_nxt;
  logic [IDX_W-1:0]  hit_slot_r, hit_slot_nxt;
  logic [RATE_W-1:0] hit_rate_r, hit_rate_nxt;
  logic              free_r, free_nxt;
  logic [IDX_W-1:0]  free_slot_r, free_slot_nxt;
  logic [RATE_W-1:0] max_r, max_nxt;

  // one entry per step: key compare, first free slot search and running max over the other entries
  always_comb begin
    hit_nxt       = hit_r;
    hit_slot_nxt  = hit_slot_r;
    hit_rate_nxt  = hit_rate_r;
    free_nxt      = free_r;
    free_slot_nxt = free_slot_r;
    max_nxt       = max_r;
    if (ctl.clear) begin
      hit_nxt  = 1'b0;
      free_nxt = 1'b0;
      max_nxt  = '0;
    end else if (ctl.step) begin
      if (ent_valid) begin
        if (!hit_r && ent_key == key) begin
          hit_nxt      = 1'b1;
          hit_slot_nxt = idx;
          hit_rate_nxt = ent_rate;
        end else if (ent_rate > max_r) begin
          max_nxt = ent_rate;
        end
      end else if (!free_r) begin
        free_nxt      = 1'b1;
        free_slot_nxt = idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
      max_r  <= '0;
    end else begin
      hit_r  <= hit_nxt;
      free_r <= free_nxt;
      max_r  <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_slot_r  <= hit_slot_nxt;
    hit_rate_r  <= hit_rate_nxt;
    free_slot_r <= free_slot_nxt;
  end

  assign hit       = hit_r;
  assign hit_slot  = hit_slot_r;
  assign hit_rate  = hit_rate_r;
  assign free      = free_r;
  assign free_slot = free_slot_r;
  assign max_other = max_r;

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`default_nettype none

module tb_top;
  import krv_pkg::*;

  localparam int unsigned ENTRIES = 32;
  localparam int unsigned RATE_W = 10;
  localparam int unsigned KEY_POOL = 40;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  typedef struct {
    logic [2:0]        cmd;
    logic [31:0]       key;
    logic [RATE_W-1:0] rate;
    logic              flag;
    int                gap;
    bit                drain;
  } rate_req_t;

  typedef struct {
    logic [RATE_W-1:0] rate;
    logic              changed;
    logic [RATE_W-1:0] sync;
    status_t           status;
  } vote_t;

  logic clk;
  logic rst_n;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_cmd = CMD_SPARE7;
  logic signed [31:0] in_node_id = '0;
  logic [RATE_W-1:0] in_rate_value = '0;
  logic in_flag_value = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [RATE_W-1:0] out_expected_rate;
  logic out_rate_changed;
  logic [RATE_W-1:0] out_display_sync_rate;
  logic [1:0] out_status;

  keyed_rate_table_max_vote #(
    .TABLE_ENTRIES(ENTRIES),
    .RATE_BITS    (RATE_W)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_cmd               (in_cmd),
    .in_node_id           (in_node_id),
    .in_rate_value        (in_rate_value),
    .in_flag_value        (in_flag_value),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_expected_rate    (out_expected_rate),
    .out_rate_changed     (out_rate_changed),
    .out_display_sync_rate(out_display_sync_rate),
    .out_status           (out_status)
  );

  // shadow copy of the rate table
  bit                tbl_used [ENTRIES];
  logic [31:0]       tbl_key  [ENTRIES];
  logic [RATE_W-1:0] tbl_rate [ENTRIES];
  logic [RATE_W-1:0] anim_rate;
  logic [RATE_W-1:0] sync_rate;
  logic              changed_flag;

  rate_req_t req_q[$];
  vote_t     vote_q[$];
  rate_req_t cur_req;
  int        gap_left;
  int        stall_left;
  int        results_seen;
  int        errors;
  int        idle_cycles;

  logic [31:0]       key_pool  [KEY_POOL];
  logic [RATE_W-1:0] rate_pool [6];
  bit                quiet;
  bit                drain_next;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic clear_table();
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_used[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_rate[i] = '0;
    end
    anim_rate = '0;
    sync_rate = '0;
    changed_flag = 1'b0;
  endtask

  // applies one command to the shadow table and returns the vote it yields
  function automatic vote_t apply_request(rate_req_t r);
    int hit;
    int free_slot;
    vote_t v;
    logic [RATE_W-1:0] best;
    hit = -1;
    free_slot = -1;
    v.status = ST_IGNORED;
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_used[i] && tbl_key[i] == r.key && hit < 0) hit = i;
      if (!tbl_used[i] && free_slot < 0) free_slot = i;
    end
    case (r.cmd)
      CMD_ADD: begin
        if (hit < 0) begin
          if (free_slot < 0) begin
            v.status = ST_FULL;
          end else begin
            tbl_used[free_slot] = 1'b1;
            tbl_key[free_slot] = r.key;
            tbl_rate[free_slot] = r.rate;
            changed_flag = 1'b1;
            v.status = ST_APPLIED;
          end
        end
      end
      CMD_REMOVE: begin
        if (hit >= 0) begin
          tbl_used[hit] = 1'b0;
          changed_flag = 1'b1;
          v.status = ST_APPLIED;
        end
      end
      CMD_UPDATE: begin
        if (hit >= 0 && tbl_rate[hit] != r.rate) begin
          tbl_rate[hit] = r.rate;
          changed_flag = 1'b1;
          v.status = ST_APPLIED;
        end
      end
      CMD_ANIM: begin
        if (anim_rate != r.rate) begin
          anim_rate = r.rate;
          changed_flag = 1'b1;
          v.status = ST_APPLIED;
        end
      end
      CMD_SYNC: begin
        if (sync_rate != r.rate) begin
          sync_rate = r.rate;
          changed_flag = 1'b1;
          v.status = ST_APPLIED;
        end
      end
      CMD_FLAG: begin
        changed_flag = r.flag;
        v.status = ST_APPLIED;
      end
      default: ;
    endcase
    best = '0;
    for (int i = 0; i < ENTRIES; i++)
      if (tbl_used[i] && tbl_rate[i] > best) best = tbl_rate[i];
    if (sync_rate > best) best = sync_rate;
    if (anim_rate > best) best = anim_rate;
    v.rate = best;
    v.changed = changed_flag;
    v.sync = sync_rate;
    return v;
  endfunction

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic push_req(logic [2:0] cmd, logic [31:0] key, logic [RATE_W-1:0] rate,
                          logic flag);
    rate_req_t r;
    r.cmd = cmd;
    r.key = key;
    r.rate = rate;
    r.flag = flag;
    r.gap = quiet ? 0 : $urandom_range(0, 4);
    r.drain = drain_next;
    drain_next = 1'b0;
    req_q.push_back(r);
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return key_pool[$urandom_range(0, KEY_POOL - 1)];
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate();
    if ($urandom_range(0, 1) == 0) return rate_pool[$urandom_range(0, 5)];
    return RATE_W'($urandom_range(0, (1 << RATE_W) - 1));
  endfunction

  function automatic bit key_taken(logic [31:0] k, int upto);
    for (int i = 0; i < upto; i++)
      if (key_pool[i] == k) return 1'b1;
    return 1'b0;
  endfunction

  task automatic push_mixed(int count);
    int w;
    for (int n = 0; n < count; n++) begin
      w = $urandom_range(0, 99);
      if (w < 30) push_req(CMD_ADD, pick_key(), pick_rate(), 1'($urandom_range(0, 1)));
      else if (w < 50) push_req(CMD_REMOVE, pick_key(), pick_rate(), 1'($urandom_range(0, 1)));
      else if (w < 75) push_req(CMD_UPDATE, pick_key(), pick_rate(), 1'($urandom_range(0, 1)));
      else if (w < 83) push_req(CMD_ANIM, pick_key(), pick_rate(), 1'($urandom_range(0, 1)));
      else if (w < 91) push_req(CMD_SYNC, pick_key(), pick_rate(), 1'($urandom_range(0, 1)));
      else if (w < 96) push_req(CMD_FLAG, pick_key(), pick_rate(), 1'($urandom_range(0, 1)));
      else push_req($urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7, pick_key(), pick_rate(),
                    1'($urandom_range(0, 1)));
    end
  endtask

  // driver
  always @(posedge clk) begin
    bit took;
    vote_t v;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
      clear_table();
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        v = apply_request(cur_req);
        vote_q.push_back(v);
        gap_left = (req_q.size() > 0) ? req_q[0].gap : 0;
      end
      if (took || !in_valid) begin
        if (req_q.size() > 0 && gap_left == 0 &&
            !(req_q[0].drain && vote_q.size() > 0)) begin
          cur_req = req_q.pop_front();
          in_cmd <= cur_req.cmd;
          in_node_id <= cur_req.key;
          in_rate_value <= cur_req.rate;
          in_flag_value <= cur_req.flag;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    vote_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
      results_seen = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (vote_q.size() == 0) begin
          report($sformatf("result with no item pending, rate %0d", out_expected_rate));
        end else begin
          want = vote_q.pop_front();
          if (out_expected_rate !== want.rate)
            report($sformatf("expected_rate got %0d want %0d", out_expected_rate, want.rate));
          if (out_rate_changed !== want.changed)
            report($sformatf("rate_changed got %0b want %0b", out_rate_changed, want.changed));
          if (out_display_sync_rate !== want.sync)
            report($sformatf("display_sync_rate got %0d want %0d",
                             out_display_sync_rate, want.sync));
          if (out_status !== want.status)
            report($sformatf("status got %0d want %0d", out_status, want.status));
        end
        results_seen++;
        // every third stretch of results runs without stalls
        stall_left = ((results_seen / 40) % 3 == 2) ? 0 : $urandom_range(0, 4);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles = 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] k;
    rst_n = 1'b0;
    errors = 0;
    quiet = 1'b0;
    drain_next = 1'b0;
    rate_pool = '{10'd0, 10'd1023, 10'd1, 10'd512, 10'd100, 10'd60};
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < KEY_POOL; i++) begin
      k = $urandom;
      while (key_taken(k, i)) k = $urandom;
      key_pool[i] = k;
    end

    // directed: key and rate extremes, every command and its no-op cases
    push_req(CMD_SYNC, '0, 10'd0, 1'b0);
    push_req(CMD_ANIM, '0, 10'd0, 1'b1);
    push_req(CMD_ADD, 32'h8000_0000, 10'd1023, 1'b0);
    push_req(CMD_ADD, 32'h8000_0000, 10'd5, 1'b0);
    push_req(CMD_ADD, 32'h7FFF_FFFF, 10'd0, 1'b1);
    push_req(CMD_ADD, 32'h0000_0000, 10'd1, 1'b0);
    push_req(CMD_ADD, 32'hFFFF_FFFF, 10'd512, 1'b0);
    push_req(CMD_UPDATE, 32'h8000_0000, 10'd1023, 1'b0);
    push_req(CMD_UPDATE, 32'h8000_0000, 10'd3, 1'b0);
    push_req(CMD_UPDATE, 32'h0001_2345, 10'd7, 1'b0);
    push_req(CMD_REMOVE, 32'h0001_2345, 10'd0, 1'b0);
    push_req(CMD_FLAG, '0, 10'd0, 1'b0);
    push_req(CMD_FLAG, '0, 10'd1023, 1'b1);
    push_req(CMD_FLAG, '0, 10'd0, 1'b0);
    push_req(CMD_ANIM, '0, 10'd1023, 1'b0);
    push_req(CMD_ANIM, '0, 10'd1023, 1'b0);
    push_req(CMD_SYNC, '0, 10'd1023, 1'b0);
    push_req(CMD_SYNC, '0, 10'd0, 1'b0);
    push_req(CMD_ANIM, '0, 10'd0, 1'b0);
    push_req(CMD_REMOVE, 32'h7FFF_FFFF, 10'd0, 1'b0);
    push_req(CMD_REMOVE, 32'hFFFF_FFFF, 10'd0, 1'b0);
    push_req(CMD_SPARE6, 32'hFFFF_FFFF, 10'd1023, 1'b1);
    push_req(CMD_SPARE7, 32'h8000_0000, 10'd1023, 1'b0);

    // random phases; each one starts only once the previous results are in
    for (int ph = 0; ph < 8; ph++) begin
      drain_next = 1'b1;
      quiet = (ph % 3 == 1);
      case (ph % 4)
        1: begin
          // more distinct keys than slots, so the table runs full
          for (int i = 0; i < 36; i++) push_req(CMD_ADD, key_pool[i], pick_rate(), 1'b0);
          push_req(CMD_ADD, $urandom, pick_rate(), 1'b1);
          push_req(CMD_UPDATE, key_pool[$urandom_range(0, 31)], pick_rate(), 1'b0);
          push_req(CMD_FLAG, '0, pick_rate(), 1'b0);
          push_req(CMD_ADD, $urandom, pick_rate(), 1'b0);
        end
        3: begin
          for (int i = 0; i < KEY_POOL; i++)
            push_req(CMD_REMOVE, key_pool[i], pick_rate(), 1'($urandom_range(0, 1)));
        end
        default: push_mixed(60);
      endcase
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (req_q.size() > 0 || in_valid || vote_q.size() > 0) @(posedge clk);
    repeat (45) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
